@@ rtl/hfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfb_pkg
// Types, constants and helper functions shared by the HJ212 frame builder.
// ----------------------------------------------------------------------------
package hfb_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [13:0] MAX_LEN  = 14'd9999;

  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  localparam logic [3:0] STEP_HASH0 = 4'd0;
  localparam logic [3:0] STEP_HASH1 = 4'd1;
  localparam logic [3:0] STEP_DIG0  = 4'd2;
  localparam logic [3:0] STEP_DIG3  = 4'd5;
  localparam logic [3:0] STEP_DATA  = 4'd6;
  localparam logic [3:0] STEP_HEX0  = 4'd7;
  localparam logic [3:0] STEP_HEX3  = 4'd10;
  localparam logic [3:0] STEP_CR    = 4'd11;
  localparam logic [3:0] STEP_LF    = 4'd12;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [13:0] seg_len;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [13:0] len;
    logic        first;
    logic        last;
    logic [15:0] crc;
  } q_entry_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = {8'h00, crc[15:8] ^ b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [13:0] dec_mult(input logic [1:0] pos, input logic [3:0] d);
    logic [13:0] scale;
    case (pos)
      2'd0:    scale = 14'd1000;
      2'd1:    scale = 14'd100;
      2'd2:    scale = 14'd10;
      default: scale = 14'd1;
    endcase
    return 14'(scale * {10'd0, d});
  endfunction

  function automatic logic [3:0] dec_digit(input logic [13:0] v, input logic [1:0] pos);
    logic [3:0] d;
    d = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (v >= dec_mult(pos, 4'(j))) begin
        d = 4'(j);
      end
    end
    return d;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (CHAR_ZERO + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

endpackage

@@ rtl/hj212_frame_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hj212_frame_builder
// Streaming HJ212 frame wrapper: "##" + length header, data, CRC-16 hex, CR LF.
//
//   Channel | Ports                          | Transaction when
//   input   | in_valid, in_stall, in_data    | in_valid && !in_stall
//   output  | out_valid, out_stall, out_data | out_valid && !out_stall
//
// A middle byte yields only its data byte; a first byte adds the "##" and length
// header, a last byte the CRC hex and CR LF; the back sequencer emits one byte per
// cycle while entries are queued and out_stall is low. Input bytes pass the queue, cur_r and out_r in turn.
// The queue (QUEUE_DEPTH entries) absorbs header and trailer bursts.
// Synchronous active-low reset empties queue and output and restarts framing.
// ----------------------------------------------------------------------------
module hj212_frame_builder #(
  parameter int unsigned QUEUE_DEPTH = hfb_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hfb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hfb_pkg::out_item_t out_data
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  hfb_pkg::q_entry_t q_wdata;
  hfb_pkg::q_entry_t q_rdata;

  hfb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  hfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  hfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/hfb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfb_front
// Accepts data bytes, tracks frame position and running CRC, builds entries.
// ----------------------------------------------------------------------------
module hfb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hfb_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output hfb_pkg::q_entry_t q_wdata
);

  logic [15:0] crc_r, crc_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [15:0] crc_base;
  logic [15:0] crc_new;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    crc_base = in_frame_r ? crc_r : hfb_pkg::CRC_INIT;
    crc_new  = hfb_pkg::crc_step(crc_base, in_data.data_byte);
  end

  always_comb begin
    q_wdata.data_byte = in_data.data_byte;
    q_wdata.len       = (in_data.seg_len > hfb_pkg::MAX_LEN) ? hfb_pkg::MAX_LEN
                                                             : in_data.seg_len;
    q_wdata.first     = !in_frame_r;
    q_wdata.last      = in_data.last_byte;
    q_wdata.crc       = crc_new;
  end

  always_comb begin
    crc_nxt      = crc_r;
    in_frame_nxt = in_frame_r;
    if (q_push) begin
      crc_nxt      = in_data.last_byte ? hfb_pkg::CRC_INIT : crc_new;
      in_frame_nxt = !in_data.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= hfb_pkg::CRC_INIT;
      in_frame_r <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && in_data.last_byte |=> !in_frame_r && crc_r == hfb_pkg::CRC_INIT)
    else $error("frame not closed after last byte");

  a_first_marks: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !in_data.last_byte |=> in_frame_r)
    else $error("frame not opened after non-last byte");

endmodule

@@ rtl/hfb_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfb_queue
// Small register queue between front and back.
// ----------------------------------------------------------------------------
module hfb_queue #(
  parameter int unsigned DEPTH = hfb_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hfb_pkg::q_entry_t wdata,
  input  logic              pop,
  output hfb_pkg::q_entry_t rdata,
  output logic              full,
  output logic              empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  hfb_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

@@ rtl/hfb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfb_back
// Sequences header, data and trailer bytes of each entry into the output register.
// ----------------------------------------------------------------------------
module hfb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  hfb_pkg::q_entry_t  q_rdata,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output hfb_pkg::out_item_t out_data
);

  logic               cur_valid_r, cur_valid_nxt;
  hfb_pkg::q_entry_t  cur_r, cur_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [13:0]        rem_r, rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  hfb_pkg::out_item_t out_r, out_nxt;

  logic       advance;
  logic       emit;
  logic       done;
  logic       load;
  logic [3:0] end_step;
  logic [1:0] dig_pos;
  logic [1:0] hex_pos;
  logic [3:0] digit;
  logic [3:0] nibble;
  logic [7:0] byte_val;
  logic       is_digit;

  assign advance  = !out_valid_r || !out_stall;
  assign emit     = cur_valid_r && advance;
  assign end_step = cur_r.last ? hfb_pkg::STEP_LF : hfb_pkg::STEP_DATA;
  assign done     = emit && (step_r == end_step);
  assign load     = (!cur_valid_r || done) && !q_empty;
  assign q_pop    = load;

  assign dig_pos  = 2'(step_r - hfb_pkg::STEP_DIG0);
  assign hex_pos  = 2'(step_r - hfb_pkg::STEP_HEX0);
  assign digit    = hfb_pkg::dec_digit(rem_r, dig_pos);

  always_comb begin
    case (hex_pos)
      2'd0:    nibble = cur_r.crc[15:12];
      2'd1:    nibble = cur_r.crc[11:8];
      2'd2:    nibble = cur_r.crc[7:4];
      default: nibble = cur_r.crc[3:0];
    endcase
  end

  always_comb begin
    is_digit = 1'b0;
    case (step_r) inside
      [hfb_pkg::STEP_HASH0:hfb_pkg::STEP_HASH1]: byte_val = hfb_pkg::CHAR_HASH;
      [hfb_pkg::STEP_DIG0:hfb_pkg::STEP_DIG3]: begin
        byte_val = hfb_pkg::CHAR_ZERO | {4'h0, digit};
        is_digit = 1'b1;
      end
      hfb_pkg::STEP_DATA:                      byte_val = cur_r.data_byte;
      [hfb_pkg::STEP_HEX0:hfb_pkg::STEP_HEX3]: byte_val = hfb_pkg::hex_char(nibble);
      hfb_pkg::STEP_CR:                        byte_val = hfb_pkg::CHAR_CR;
      hfb_pkg::STEP_LF:                        byte_val = hfb_pkg::CHAR_LF;
      default:                                 byte_val = hfb_pkg::CHAR_LF;
    endcase
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    if (load) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_rdata;
      step_nxt      = q_rdata.first ? hfb_pkg::STEP_HASH0 : hfb_pkg::STEP_DATA;
      rem_nxt       = q_rdata.len;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      step_nxt = step_r + 1'b1;
      if (is_digit) begin
        rem_nxt = rem_r - hfb_pkg::dec_mult(dig_pos, digit);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt     = 1'b1;
      out_nxt.out_byte  = byte_val;
      out_nxt.frame_end = (step_r == hfb_pkg::STEP_LF);
      out_nxt.run_last  = (step_r == end_step);
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= hfb_pkg::STEP_HASH0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    rem_r <= rem_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.frame_end |-> out_r.run_last)
    else $error("frame end without run last");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> step_r <= end_step)
    else $error("sequencer step past end");

endmodule
